@@ hw/rtl/rme_pkg.sv @@
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types, constants and the arctangent table for the rotation matrix
// to Euler angles pipeline.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int CORDIC_LAT    = CORDIC_N + 2;
    localparam int SQRT_STAGES   = 16;

    localparam int DW        = 16;  // matrix element width
    localparam int OW        = 17;  // CORDIC operand width
    localparam int CW        = 44;  // CORDIC vector width
    localparam int AW        = 26;  // angle accumulator width
    localparam int PRESCALE  = 24;
    localparam int RW        = 18;  // square root remainder width

    localparam logic signed [AW-1:0] DEG90     = AW'(5898240);
    localparam logic signed [AW-1:0] ROUND_ADD = AW'(256);
    localparam logic signed [AW-1:0] OUT_MAX   = AW'(23040);
    localparam logic signed [AW-1:0] OUT_MIN   = -AW'(23040);

    localparam int            ADDR_W       = 3;
    localparam logic          REG_VERT_THR = 1'b0;
    localparam logic [14:0]   THR_RESET    = 15'd33;

    typedef logic signed [DW-1:0] elem_t;
    typedef logic signed [OW-1:0] opnd_t;

    typedef struct packed {
        elem_t fwd_x;
        elem_t fwd_y;
        elem_t fwd_z;
        elem_t left_x;
        elem_t left_y;
        elem_t left_z;
        elem_t up_z;
    } side_t;

    function automatic logic signed [AW-1:0] atan_entry(input int unsigned i);
        logic signed [AW-1:0] v;
        case (i)
            0:  v = AW'(2949120);
            1:  v = AW'(1740967);
            2:  v = AW'(919879);
            3:  v = AW'(466945);
            4:  v = AW'(234379);
            5:  v = AW'(117304);
            6:  v = AW'(58666);
            7:  v = AW'(29335);
            8:  v = AW'(14668);
            9:  v = AW'(7334);
            10: v = AW'(3667);
            11: v = AW'(1833);
            12: v = AW'(917);
            13: v = AW'(458);
            14: v = AW'(229);
            15: v = AW'(115);
            16: v = AW'(57);
            17: v = AW'(29);
            18: v = AW'(14);
            19: v = AW'(7);
            20: v = AW'(4);
            21: v = AW'(2);
            22: v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/rme_if.sv @@
// ----------------------------------------------------------------------------
// rme_in_if / rme_out_if
// Valid/ready channels carrying matrix elements in and Euler angles out.
// ----------------------------------------------------------------------------
interface rme_in_if;
    logic          valid;
    logic          ready;
    rme_pkg::elem_t fwd_x;
    rme_pkg::elem_t fwd_y;
    rme_pkg::elem_t fwd_z;
    rme_pkg::elem_t left_x;
    rme_pkg::elem_t left_y;
    rme_pkg::elem_t left_z;
    rme_pkg::elem_t up_z;

    modport source (output valid, fwd_x, fwd_y, fwd_z, left_x, left_y, left_z, up_z,
                    input ready);
    modport sink   (input valid, fwd_x, fwd_y, fwd_z, left_x, left_y, left_z, up_z,
                    output ready);
endinterface

interface rme_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic signed [15:0] roll_deg;
    logic               near_vertical;

    modport source (output valid, pitch_deg, yaw_deg, roll_deg, near_vertical,
                    input ready);
    modport sink   (input valid, pitch_deg, yaw_deg, roll_deg, near_vertical,
                    output ready);
endinterface

@@ hw/rtl/rme_sqrt.sv @@
// ----------------------------------------------------------------------------
// rme_sqrt
// Pipelined integer square root, one result bit per stage, carrying the
// matrix elements and the valid bit alongside.
// ----------------------------------------------------------------------------
module rme_sqrt
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ce,
    input  logic               in_vld,
    input  logic [31:0]        in_sum,
    input  rme_pkg::side_t     in_side,
    output logic               out_vld,
    output logic [15:0]        out_root,
    output rme_pkg::side_t     out_side
);

    logic                        vld_reg  [1:rme_pkg::SQRT_STAGES];
    logic [31:0]                 n_reg    [1:rme_pkg::SQRT_STAGES];
    logic [rme_pkg::RW-1:0]      rem_reg  [1:rme_pkg::SQRT_STAGES];
    logic [15:0]                 res_reg  [1:rme_pkg::SQRT_STAGES];
    rme_pkg::side_t              side_reg [1:rme_pkg::SQRT_STAGES];

    for (genvar k = 0; k < rme_pkg::SQRT_STAGES; k++) begin : g_stage
        localparam int B = rme_pkg::SQRT_STAGES - 1 - k;

        logic                   vld_prev;
        logic [31:0]            n_prev;
        logic [rme_pkg::RW-1:0] rem_prev;
        logic [15:0]            res_prev;
        rme_pkg::side_t         side_prev;
        logic [rme_pkg::RW+1:0] rem_sh;
        logic [rme_pkg::RW+1:0] trial;
        logic [rme_pkg::RW-1:0] rem_next;
        logic [15:0]            res_next;

        if (k == 0) begin : g_first
            assign vld_prev  = in_vld;
            assign n_prev    = in_sum;
            assign rem_prev  = '0;
            assign res_prev  = '0;
            assign side_prev = in_side;
        end else begin : g_rest
            assign vld_prev  = vld_reg[k];
            assign n_prev    = n_reg[k];
            assign rem_prev  = rem_reg[k];
            assign res_prev  = res_reg[k];
            assign side_prev = side_reg[k];
        end

        always_comb
        begin
            rem_sh = {rem_prev, n_prev[2*B+1 -: 2]};
            trial  = {2'b00, res_prev, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next = rme_pkg::RW'(rem_sh - trial);
                res_next = {res_prev[14:0], 1'b1};
            end
            else
            begin
                rem_next = rme_pkg::RW'(rem_sh);
                res_next = {res_prev[14:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[k+1] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                n_reg[k+1]    <= n_prev;
                rem_reg[k+1]  <= rem_next;
                res_reg[k+1]  <= res_next;
                side_reg[k+1] <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[rme_pkg::SQRT_STAGES];
    assign out_root = res_reg[rme_pkg::SQRT_STAGES];
    assign out_side = side_reg[rme_pkg::SQRT_STAGES];

endmodule

@@ hw/rtl/rme_cordic.sv @@
// ----------------------------------------------------------------------------
// rme_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in 1/128 degree: a
// quadrant stage, one stage per micro-rotation and a rounding stage.
// ----------------------------------------------------------------------------
module rme_cordic
(
    input  logic                 clk,
    input  logic                 ce,
    input  rme_pkg::opnd_t       y,
    input  rme_pkg::opnd_t       x,
    output logic signed [15:0]   angle
);

    localparam int N = rme_pkg::CORDIC_N;
    localparam int CW = rme_pkg::CW;
    localparam int AW = rme_pkg::AW;

    logic signed [CW-1:0] x_reg    [0:N];
    logic signed [CW-1:0] y_reg    [0:N];
    logic signed [AW-1:0] z_reg    [0:N];
    logic                 zero_reg [0:N];
    logic signed [15:0]   angle_reg;

    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [AW-1:0] z0;

    // Vectors in the left half-plane are turned by a quarter first.
    always_comb
    begin
        xe = {{(CW - rme_pkg::OW - rme_pkg::PRESCALE){x[rme_pkg::OW-1]}}, x,
              {rme_pkg::PRESCALE{1'b0}}};
        ye = {{(CW - rme_pkg::OW - rme_pkg::PRESCALE){y[rme_pkg::OW-1]}}, y,
              {rme_pkg::PRESCALE{1'b0}}};
        x0 = xe;
        y0 = ye;
        z0 = '0;
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                x0 = ye;
                y0 = -xe;
                z0 = rme_pkg::DEG90;
            end
            else
            begin
                x0 = -ye;
                y0 = xe;
                z0 = -rme_pkg::DEG90;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0]    <= x0;
            y_reg[0]    <= y0;
            z_reg[0]    <= z0;
            zero_reg[0] <= (x == '0) && (y == '0);
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + rme_pkg::atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - rme_pkg::atan_entry(i);
                end
            end
        end
    end

    logic signed [AW-1:0] z_rnd;
    logic signed [AW-1:0] z_deg;
    logic signed [15:0]   angle_next;

    always_comb
    begin
        z_rnd = z_reg[N] + rme_pkg::ROUND_ADD;
        z_deg = z_rnd >>> 9;
        if (zero_reg[N])
            angle_next = '0;
        else if (z_deg > rme_pkg::OUT_MAX)
            angle_next = 16'(rme_pkg::OUT_MAX);
        else if (z_deg < rme_pkg::OUT_MIN)
            angle_next = 16'(rme_pkg::OUT_MIN);
        else
            angle_next = z_deg[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

@@ hw/rtl/rotation_matrix_to_euler_angles_top.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_top
// Converts rotation matrix columns to pitch, yaw and roll in 1/128 degree.
// ----------------------------------------------------------------------------
// The block takes one matrix transaction in every cycle while the output is
// not stalled and gives one angle transaction per matrix, in order, through
// a squaring stage and a summing stage, sixteen square root stages, one
// branch select stage and the eighteen stages of the CORDIC units. The whole
// pipeline advances together and holds when the output is valid but not
// taken. The near-vertical threshold sits at byte address 0 of the APB
// port and should be written only while the pipeline is empty.
module rotation_matrix_to_euler_angles_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rme_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    rme_in_if.sink                      item_in,
    rme_out_if.source                   item_out
);

    logic        ce;
    logic [14:0] thr_reg;

    assign ce            = !item_out.valid || item_out.ready;
    assign item_in.ready = ce;
    assign pready        = 1'b1;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= rme_pkg::THR_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == rme_pkg::REG_VERT_THR))
        begin
            thr_reg <= pwdata[14:0];
        end
    end

    assign prdata = (paddr[2] == rme_pkg::REG_VERT_THR) ? {17'd0, thr_reg} : 32'd0;

    // Squares and their sum
    logic                  sq_vld_reg;
    logic [30:0]           sqx_reg;
    logic [30:0]           sqy_reg;
    rme_pkg::side_t        sq_side_reg;
    logic                  sum_vld_reg;
    logic [31:0]           sum_reg;
    rme_pkg::side_t        sum_side_reg;
    logic signed [31:0]    px;
    logic signed [31:0]    py;

    assign px = item_in.fwd_x * item_in.fwd_x;
    assign py = item_in.fwd_y * item_in.fwd_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= 1'b0;
            sum_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            sq_vld_reg  <= item_in.valid;
            sum_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sqx_reg      <= px[30:0];
            sqy_reg      <= py[30:0];
            sq_side_reg  <= '{item_in.fwd_x, item_in.fwd_y, item_in.fwd_z,
                               item_in.left_x, item_in.left_y, item_in.left_z,
                               item_in.up_z};
            sum_reg      <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            sum_side_reg <= sq_side_reg;
        end
    end

    logic           rt_vld;
    logic [15:0]    rt_root;
    rme_pkg::side_t rt_side;

    rme_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (ce),
        .in_vld   (sum_vld_reg),
        .in_sum   (sum_reg),
        .in_side  (sum_side_reg),
        .out_vld  (rt_vld),
        .out_root (rt_root),
        .out_side (rt_side)
    );

    // Branch select
    function automatic rme_pkg::opnd_t ext(input rme_pkg::elem_t e);
        return {e[rme_pkg::DW-1], e};
    endfunction

    logic           far;
    logic           sel_vld_reg;
    logic           sel_nv_reg;
    rme_pkg::opnd_t py_reg;
    rme_pkg::opnd_t pxo_reg;
    rme_pkg::opnd_t yy_reg;
    rme_pkg::opnd_t yx_reg;
    rme_pkg::opnd_t ry_reg;
    rme_pkg::opnd_t rx_reg;

    assign far = rt_root > {1'b0, thr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            sel_vld_reg <= rt_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sel_nv_reg <= !far;
            py_reg     <= -ext(rt_side.fwd_z);
            pxo_reg    <= {1'b0, rt_root};
            yy_reg     <= far ? ext(rt_side.fwd_y) : -ext(rt_side.left_x);
            yx_reg     <= far ? ext(rt_side.fwd_x) : ext(rt_side.left_y);
            // The near-vertical roll is fed as a zero vector, which yields zero.
            ry_reg     <= far ? ext(rt_side.left_z) : '0;
            rx_reg     <= far ? ext(rt_side.up_z) : '0;
        end
    end

    rme_cordic u_pitch (.clk(clk), .ce(ce), .y(py_reg), .x(pxo_reg),
                        .angle(item_out.pitch_deg));
    rme_cordic u_yaw   (.clk(clk), .ce(ce), .y(yy_reg), .x(yx_reg),
                        .angle(item_out.yaw_deg));
    rme_cordic u_roll  (.clk(clk), .ce(ce), .y(ry_reg), .x(rx_reg),
                        .angle(item_out.roll_deg));

    logic cv_reg [0:rme_pkg::CORDIC_LAT-1];
    logic cn_reg [0:rme_pkg::CORDIC_LAT-1];

    for (genvar s = 0; s < rme_pkg::CORDIC_LAT; s++) begin : g_tag
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[s] <= 1'b0;
            end
            else if (ce)
            begin
                cv_reg[s] <= (s == 0) ? sel_vld_reg : cv_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                cn_reg[s] <= (s == 0) ? sel_nv_reg : cn_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign item_out.valid         = cv_reg[rme_pkg::CORDIC_LAT-1];
    assign item_out.near_vertical = cn_reg[rme_pkg::CORDIC_LAT-1];

    a_nv_roll: assert property (@(posedge clk) disable iff (!rst_n)
        item_out.valid && item_out.near_vertical |-> item_out.roll_deg == 16'sd0)
        else $error("roll not zero in near-vertical case");

    a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
        item_out.valid |-> (item_out.pitch_deg <= 16'sd23040)
                        && (item_out.pitch_deg >= -16'sd23040))
        else $error("pitch out of range");

    a_yaw_rng: assert property (@(posedge clk) disable iff (!rst_n)
        item_out.valid |-> (item_out.yaw_deg <= 16'sd23040)
                        && (item_out.yaw_deg >= -16'sd23040))
        else $error("yaw out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_out.valid && !item_out.ready |=> item_out.valid && $stable(sel_vld_reg))
        else $error("pipeline advanced during a stall");

endmodule
